/* rtl/lrupl_pkg.sv */
// shared types, codes and constants for the page recency list
`timescale 1ns / 1ps

package lrupl_pkg;

    localparam int PAGE_W   = 6;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam int LIST_DEPTH_DEF = 16;
    localparam int PAGE_COUNT_DEF = 64;

    // request codes
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ACCESS = 2'd1;
    localparam logic [REQ_W-1:0] REQ_EVICT  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_SETRES = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    // pointer load sources
    localparam logic [1:0] PTR_ZERO  = 2'd0;
    localparam logic [1:0] PTR_LEN   = 2'd1;
    localparam logic [1:0] PTR_HIT   = 2'd2;
    localparam logic [1:0] PTR_EVICT = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [PAGE_W-1:0] page_number;
        logic              resident;
    } lrupl_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PAGE_W-1:0]   result_page;
        logic [COUNT_W-1:0]  entry_count;
    } lrupl_rsp_t;

    typedef struct packed {
        logic       capture;
        logic       clr_result;
        logic       ptr_load;
        logic [1:0] ptr_sel;
        logic       issue_dn;
        logic       issue_up;
        logic       flush;
        logic       wr_down;
        logic       wr_up;
        logic       wr_front;
        logic       inc_len;
        logic       dec_len;
        logic       res_wr;
        logic       evict_capture;
    } lrupl_cmd_t;

    typedef struct packed {
        logic full;
        logic fwd_hit;
        logic back_hit;
        logic back_miss;
        logic up_end;
        logic dn_end;
    } lrupl_sts_t;

    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
    } lrupl_fin_t;

endpackage

/* rtl/lrupl_dpath.sv */
// datapath: list memory with pointer, read pipeline, residency store and length
`timescale 1ns / 1ps

module lrupl_dpath #(
    parameter int LIST_DEPTH = lrupl_pkg::LIST_DEPTH_DEF,
    parameter int PAGE_COUNT = lrupl_pkg::PAGE_COUNT_DEF,
    localparam int CNT_W = $clog2(LIST_DEPTH + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  lrupl_pkg::lrupl_req_t           req,
    input  lrupl_pkg::lrupl_cmd_t           cmd,
    output lrupl_pkg::lrupl_sts_t           sts,
    output logic [CNT_W-1:0]                len,
    output logic [lrupl_pkg::PAGE_W-1:0]    result_page
);

    localparam int IDX_W     = $clog2(LIST_DEPTH);
    localparam int PW        = lrupl_pkg::PAGE_W;
    localparam int PAGE_SPAN = 1 << PW;
    localparam int RES_DEPTH = (PAGE_COUNT < PAGE_SPAN) ? PAGE_COUNT : PAGE_SPAN;
    localparam int RES_AW    = $clog2(RES_DEPTH);
    localparam logic [PW:0] PAGE_LIM = (PW + 1)'(RES_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(LIST_DEPTH);

    logic [PW-1:0]    list_mem [LIST_DEPTH];
    logic             res_mem  [RES_DEPTH];
    logic [RES_DEPTH-1:0] res_set_reg, res_set_next;

    logic [PW-1:0]    page_reg;
    logic             resident_reg;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [CNT_W-1:0] ptr_m1;

    logic             rd_vld_reg;
    logic [IDX_W-1:0] rd_pos_reg;
    logic [PW-1:0]    rd_data_reg;

    logic             vld2_reg;
    logic [IDX_W-1:0] pos2_reg;
    logic [PW-1:0]    page2_reg;
    logic             range2_reg;
    logic             res_bit_reg;
    logic             res_set_bit_reg;

    logic [PW-1:0]    result_page_reg;

    logic             issue_dn_go, issue_up_go, issue_go;
    logic [IDX_W-1:0] rd_addr;
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [PW-1:0]    wdata;
    logic             req_in_range, rd_in_range;

    assign ptr_m1      = ptr_reg - CNT_W'(1);
    assign issue_dn_go = cmd.issue_dn && (ptr_reg != '0) && !cmd.ptr_load && !cmd.flush;
    assign issue_up_go = cmd.issue_up && (ptr_reg < len_reg) && !cmd.ptr_load && !cmd.flush;
    assign issue_go    = issue_dn_go || issue_up_go;
    assign rd_addr     = issue_dn_go ? ptr_m1[IDX_W-1:0] : ptr_reg[IDX_W-1:0];

    assign req_in_range = {1'b0, page_reg} < PAGE_LIM;
    assign rd_in_range  = {1'b0, rd_data_reg} < PAGE_LIM;

    // pointer
    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.ptr_load)
        begin
            unique case (cmd.ptr_sel)
                lrupl_pkg::PTR_ZERO:  ptr_next = '0;
                lrupl_pkg::PTR_LEN:   ptr_next = len_reg;
                lrupl_pkg::PTR_HIT:   ptr_next = CNT_W'(rd_pos_reg);
                lrupl_pkg::PTR_EVICT: ptr_next = CNT_W'(pos2_reg) + CNT_W'(1);
            endcase
        end
        else if (issue_dn_go)
        begin
            ptr_next = ptr_m1;
        end
        else if (issue_up_go)
        begin
            ptr_next = ptr_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        len_next = len_reg;
        if (cmd.inc_len)
        begin
            len_next = len_reg + CNT_W'(1);
        end
        else if (cmd.dec_len)
        begin
            len_next = len_reg - CNT_W'(1);
        end
    end

    // single list write port
    always_comb
    begin
        we    = 1'b0;
        waddr = '0;
        wdata = rd_data_reg;
        priority if (cmd.wr_front)
        begin
            we    = 1'b1;
            waddr = '0;
            wdata = page_reg;
        end
        else if (cmd.wr_down && rd_vld_reg)
        begin
            we    = 1'b1;
            waddr = rd_pos_reg + IDX_W'(1);
        end
        else if (cmd.wr_up && rd_vld_reg)
        begin
            we    = 1'b1;
            waddr = rd_pos_reg - IDX_W'(1);
        end
        else
        begin
            we    = 1'b0;
        end
    end

    always_comb
    begin
        res_set_next = res_set_reg;
        if (cmd.res_wr && req_in_range)
        begin
            res_set_next[page_reg[RES_AW-1:0]] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg     <= '0;
            len_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            vld2_reg    <= 1'b0;
            res_set_reg <= '0;
        end
        else
        begin
            ptr_reg     <= ptr_next;
            len_reg     <= len_next;
            rd_vld_reg  <= issue_go;
            vld2_reg    <= rd_vld_reg && !cmd.flush;
            res_set_reg <= res_set_next;
        end
    end

    // list memory
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            list_mem[waddr] <= wdata;
        end
        if (issue_go)
        begin
            rd_data_reg <= list_mem[rd_addr];
            rd_pos_reg  <= rd_addr;
        end
    end

    // residency memory, looked up with the page just read from the list
    always_ff @(posedge clk)
    begin
        if (cmd.res_wr && req_in_range)
        begin
            res_mem[page_reg[RES_AW-1:0]] <= resident_reg;
        end
        res_bit_reg     <= res_mem[rd_data_reg[RES_AW-1:0]];
        res_set_bit_reg <= res_set_reg[rd_data_reg[RES_AW-1:0]];
        range2_reg      <= rd_in_range;
        page2_reg       <= rd_data_reg;
        pos2_reg        <= rd_pos_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            page_reg     <= req.page_number;
            resident_reg <= req.resident;
        end
        if (cmd.clr_result)
        begin
            result_page_reg <= '0;
        end
        else if (cmd.evict_capture)
        begin
            result_page_reg <= page2_reg;
        end
    end

    assign sts.full      = (len_reg == DEPTH_CNT);
    assign sts.fwd_hit   = rd_vld_reg && (rd_data_reg == page_reg);
    assign sts.back_hit  = vld2_reg && range2_reg && res_set_bit_reg && res_bit_reg;
    assign sts.up_end    = !rd_vld_reg && (ptr_reg >= len_reg);
    assign sts.dn_end    = !rd_vld_reg && (ptr_reg == '0);
    assign sts.back_miss = sts.dn_end && !vld2_reg;

    assign len         = len_reg;
    assign result_page = result_page_reg;

    a_no_grow_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.inc_len |-> !sts.full)
        else $error("list grows past its depth");

    a_no_shrink_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.dec_len |-> (len_reg != '0))
        else $error("list shrinks below empty");

    a_evict_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.evict_capture |-> sts.back_hit)
        else $error("evict captured without a resident entry");

endmodule

/* rtl/lrupl_ctrl.sv */
// controller state machine sequencing scans and shifts of the recency list
`timescale 1ns / 1ps

module lrupl_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [lrupl_pkg::REQ_W-1:0]       req_type,
    input  lrupl_pkg::lrupl_sts_t             sts,
    output logic                              busy,
    output lrupl_pkg::lrupl_cmd_t             cmd,
    output lrupl_pkg::lrupl_fin_t             fin
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_SCAN_FWD  = 3'd1;
    localparam logic [2:0] S_SCAN_BACK = 3'd2;
    localparam logic [2:0] S_SHIFT_DN  = 3'd3;
    localparam logic [2:0] S_SHIFT_UP  = 3'd4;
    localparam logic [2:0] S_FRONT     = 3'd5;
    localparam logic [2:0] S_SETRES    = 3'd6;
    localparam logic [2:0] S_DONE      = 3'd7;

    logic [2:0]                         state_reg, state_next;
    logic [lrupl_pkg::REQ_W-1:0]        op_reg, op_next;
    logic [lrupl_pkg::STATUS_W-1:0]     status_reg, status_next;

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        status_next = status_reg;
        cmd         = '0;
        fin         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture    = 1'b1;
                    cmd.clr_result = 1'b1;
                    op_next        = req_type;
                    status_next    = lrupl_pkg::ST_DONE;
                    unique case (req_type)
                        lrupl_pkg::REQ_INSERT:
                        begin
                            if (sts.full)
                            begin
                                status_next = lrupl_pkg::ST_FULL;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                cmd.ptr_load = 1'b1;
                                cmd.ptr_sel  = lrupl_pkg::PTR_LEN;
                                state_next   = S_SHIFT_DN;
                            end
                        end
                        lrupl_pkg::REQ_ACCESS:
                        begin
                            cmd.ptr_load = 1'b1;
                            cmd.ptr_sel  = lrupl_pkg::PTR_ZERO;
                            state_next   = S_SCAN_FWD;
                        end
                        lrupl_pkg::REQ_EVICT:
                        begin
                            cmd.ptr_load = 1'b1;
                            cmd.ptr_sel  = lrupl_pkg::PTR_LEN;
                            state_next   = S_SCAN_BACK;
                        end
                        lrupl_pkg::REQ_SETRES:
                        begin
                            state_next = S_SETRES;
                        end
                    endcase
                end
            end
            S_SCAN_FWD:
            begin
                priority if (sts.fwd_hit)
                begin
                    cmd.flush    = 1'b1;
                    cmd.ptr_load = 1'b1;
                    cmd.ptr_sel  = lrupl_pkg::PTR_HIT;
                    state_next   = S_SHIFT_DN;
                end
                else if (sts.up_end)
                begin
                    status_next = lrupl_pkg::ST_NONE;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.issue_up = 1'b1;
                end
            end
            S_SCAN_BACK:
            begin
                priority if (sts.back_hit)
                begin
                    cmd.flush         = 1'b1;
                    cmd.evict_capture = 1'b1;
                    cmd.ptr_load      = 1'b1;
                    cmd.ptr_sel       = lrupl_pkg::PTR_EVICT;
                    state_next        = S_SHIFT_UP;
                end
                else if (sts.back_miss)
                begin
                    status_next = lrupl_pkg::ST_NONE;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.issue_dn = 1'b1;
                end
            end
            S_SHIFT_DN:
            begin
                cmd.issue_dn = 1'b1;
                cmd.wr_down  = 1'b1;
                if (sts.dn_end)
                begin
                    state_next = S_FRONT;
                end
            end
            S_SHIFT_UP:
            begin
                cmd.issue_up = 1'b1;
                cmd.wr_up    = 1'b1;
                if (sts.up_end)
                begin
                    cmd.dec_len = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_FRONT:
            begin
                cmd.wr_front = 1'b1;
                cmd.inc_len  = (op_reg == lrupl_pkg::REQ_INSERT);
                state_next   = S_DONE;
            end
            S_SETRES:
            begin
                cmd.res_wr = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                fin.valid  = 1'b1;
                fin.status = status_reg;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            op_reg     <= lrupl_pkg::REQ_INSERT;
            status_reg <= lrupl_pkg::ST_DONE;
        end
        else
        begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            status_reg <= status_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

/* rtl/lru_page_recency_list_core.sv */
// top level of the page recency list: controller, datapath and result register
`timescale 1ns / 1ps

// Page recency list. Keeps up to LIST_DEPTH page numbers ordered most recent
// first, plus one residency flag per page (all clear after reset). A request
// transfer happens on a rising edge with start high and busy low; busy stays
// high while the request is worked on. Every request gives exactly one result,
// shown on result for a single cycle with done high; the receiver cannot hold
// it off, so capture it in that cycle. The next request may be started in the
// cycle done is high. Insert, access and evict run longer the more entries they
// scan or shift; this is set by the list memory's single read port with its
// registered read data: scans and shifts move one entry per cycle, and evict
// adds one more registered lookup into the residency store. Page numbers at or
// above PAGE_COUNT read as not resident; setting their residency is ignored but
// still reports done. entry_count is the list length after the request, kept to
// its low five bits.
module lru_page_recency_list_core #(
    parameter int LIST_DEPTH = lrupl_pkg::LIST_DEPTH_DEF,
    parameter int PAGE_COUNT = lrupl_pkg::PAGE_COUNT_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  lrupl_pkg::lrupl_req_t request,
    output logic                  busy,
    output logic                  done,
    output lrupl_pkg::lrupl_rsp_t result
);

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int CW    = lrupl_pkg::COUNT_W;

    // controller to datapath command and status
    lrupl_pkg::lrupl_cmd_t cmd;
    lrupl_pkg::lrupl_sts_t sts;
    lrupl_pkg::lrupl_fin_t fin;

    logic [CNT_W-1:0]              len;
    logic [lrupl_pkg::PAGE_W-1:0]  result_page;
    logic [CNT_W+CW-1:0]           len_ext;

    // output register for the result transfer
    logic                  done_reg;
    lrupl_pkg::lrupl_rsp_t result_reg, result_next;

    lrupl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (request.req_type),
        .sts      (sts),
        .busy     (busy),
        .cmd      (cmd),
        .fin      (fin)
    );

    lrupl_dpath #(
        .LIST_DEPTH (LIST_DEPTH),
        .PAGE_COUNT (PAGE_COUNT)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (request),
        .cmd         (cmd),
        .sts         (sts),
        .len         (len),
        .result_page (result_page)
    );

    // entry count carries the low bits of the length, zero extended if narrower
    assign len_ext = {{CW{1'b0}}, len};

    always_comb
    begin
        result_next             = result_reg;
        result_next.status      = fin.status;
        result_next.result_page = result_page;
        result_next.entry_count = len_ext[CW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= fin.valid;
        end
    end

    // payload, loaded only when a result is finished
    always_ff @(posedge clk)
    begin
        if (fin.valid)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_done_follows_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result shown without a request in progress");

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_full_no_page: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == lrupl_pkg::ST_FULL)) |-> (result.result_page == '0))
        else $error("full status carries a page number");

endmodule

/* tb/lru_page_recency_list_checker.sv */
// checker for the page recency list: request/result monitor, predictor and compare
`timescale 1ns / 1ps

module lru_page_recency_list_checker #(
    parameter int LIST_DEPTH = lrupl_pkg::LIST_DEPTH_DEF,
    parameter int PAGE_COUNT = lrupl_pkg::PAGE_COUNT_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  lrupl_pkg::lrupl_req_t request,
    input  logic                  done,
    input  lrupl_pkg::lrupl_rsp_t result,
    output int                    error_count,
    output int                    pending_count,
    output int                    checked_count,
    output int                    full_count,
    output int                    none_count
);
    import lrupl_pkg::*;

    // shadow copy of the list and the residency flags
    logic [PAGE_W-1:0] recency_shadow [LIST_DEPTH];
    int unsigned       shadow_len;
    bit                resident_shadow [PAGE_COUNT];

    lrupl_rsp_t expected_rsp_q [$];

    int mismatches = 0;
    int checked    = 0;
    int fulls      = 0;
    int nones      = 0;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic bit page_is_resident(input logic [PAGE_W-1:0] page);
        if (int'(page) >= PAGE_COUNT)
            return 1'b0;
        return resident_shadow[page];
    endfunction

    // applies one request to the shadow state and returns its result
    function automatic lrupl_rsp_t predict_request(input lrupl_req_t r);
        lrupl_rsp_t rsp;
        int         pos;
        int         i;
        rsp.status      = ST_DONE;
        rsp.result_page = '0;
        pos             = -1;
        case (r.req_type)
            REQ_INSERT:
            begin
                if (shadow_len >= LIST_DEPTH)
                    rsp.status = ST_FULL;
                else
                begin
                    for (i = int'(shadow_len); i > 0; i--)
                        recency_shadow[i] = recency_shadow[i-1];
                    recency_shadow[0] = r.page_number;
                    shadow_len++;
                end
            end
            REQ_ACCESS:
            begin
                for (i = 0; i < int'(shadow_len); i++)
                    if (pos < 0 && recency_shadow[i] == r.page_number)
                        pos = i;
                if (pos < 0)
                    rsp.status = ST_NONE;
                else
                begin
                    for (i = pos; i > 0; i--)
                        recency_shadow[i] = recency_shadow[i-1];
                    recency_shadow[0] = r.page_number;
                end
            end
            REQ_EVICT:
            begin
                for (i = int'(shadow_len) - 1; i >= 0; i--)
                    if (pos < 0 && page_is_resident(recency_shadow[i]))
                        pos = i;
                if (pos < 0)
                    rsp.status = ST_NONE;
                else
                begin
                    rsp.result_page = recency_shadow[pos];
                    for (i = pos; i + 1 < int'(shadow_len); i++)
                        recency_shadow[i] = recency_shadow[i+1];
                    shadow_len--;
                end
            end
            default:
            begin
                if (int'(r.page_number) < PAGE_COUNT)
                    resident_shadow[r.page_number] = r.resident;
            end
        endcase
        rsp.entry_count = COUNT_W'(shadow_len);
        return rsp;
    endfunction

    always @(posedge clk)
    begin
        lrupl_rsp_t want;
        lrupl_rsp_t predicted;
        if (!rst_n)
        begin
            shadow_len = 0;
            for (int p = 0; p < PAGE_COUNT; p++)
                resident_shadow[p] = 1'b0;
            for (int e = 0; e < LIST_DEPTH; e++)
                recency_shadow[e] = '0;
            expected_rsp_q.delete();
        end
        else
        begin
            // result first: a new request in the same cycle is always younger
            if (done)
            begin
                if (expected_rsp_q.size() == 0)
                    report_mismatch($sformatf("result with nothing pending: status %0d page %0d count %0d",
                                              result.status, result.result_page, result.entry_count));
                else
                begin
                    want = expected_rsp_q.pop_front();
                    checked++;
                    if (result.status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  result.status, want.status));
                    if (result.result_page !== want.result_page)
                        report_mismatch($sformatf("result_page got %0d want %0d",
                                                  result.result_page, want.result_page));
                    if (result.entry_count !== want.entry_count)
                        report_mismatch($sformatf("entry_count got %0d want %0d",
                                                  result.entry_count, want.entry_count));
                end
            end
            if (start && !busy)
            begin
                predicted = predict_request(request);
                if (predicted.status == ST_FULL)
                    fulls++;
                if (predicted.status == ST_NONE)
                    nones++;
                expected_rsp_q.push_back(predicted);
            end
        end
        error_count   <= mismatches;
        pending_count <= expected_rsp_q.size();
        checked_count <= checked;
        full_count    <= fulls;
        none_count    <= nones;
    end

endmodule

/* tb/lru_page_recency_list_core_tb.sv */
// testbench top for the page recency list: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module lru_page_recency_list_core_tb;
    import lrupl_pkg::*;

    localparam int LIST_DEPTH    = LIST_DEPTH_DEF;
    localparam int PAGE_COUNT    = PAGE_COUNT_DEF;
    // the longest request is an evict from the far end of the list
    localparam int DRAIN_CYCLES  = 4 * LIST_DEPTH + 16;
    // no transfer for this long means the block is stuck
    localparam int WATCHDOG_MAX  = 2000;
    localparam int MAX_GAP       = 20;
    localparam int PHASE_ITEMS   = 470;

    logic       clk     = 1'b0;
    logic       rst_n   = 1'b0;
    logic       start   = 1'b0;
    lrupl_req_t request = '0;
    logic       busy;
    logic       done;
    lrupl_rsp_t result;

    int error_count;
    int pending_count;
    int checked_count;
    int full_count;
    int none_count;

    int sent_by_type [4] = '{0, 0, 0, 0};
    int idle_cycles      = 0;

    // 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    lru_page_recency_list_core #(
        .LIST_DEPTH (LIST_DEPTH),
        .PAGE_COUNT (PAGE_COUNT)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    lru_page_recency_list_checker #(
        .LIST_DEPTH (LIST_DEPTH),
        .PAGE_COUNT (PAGE_COUNT)
    ) recency_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .request       (request),
        .done          (done),
        .result        (result),
        .error_count   (error_count),
        .pending_count (pending_count),
        .checked_count (checked_count),
        .full_count    (full_count),
        .none_count    (none_count)
    );

    // watchdog: counts cycles with neither a request nor a result transfer
    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_MAX)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d results pending",
                     idle_cycles, pending_count);
            $display("status: fail");
            $finish;
        end
    end

    function automatic lrupl_req_t page_req(input logic [REQ_W-1:0] kind,
                                            input int page, input logic res);
        lrupl_req_t r;
        r.req_type    = kind;
        r.page_number = PAGE_W'(page);
        r.resident    = res;
        return r;
    endfunction

    // one request transfer; optional random gap with start low before it
    task automatic send_request(input lrupl_req_t r, input int idle_pct);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= r;
        // transfer happens at the first edge that sees busy low
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent_by_type[r.req_type]++;
    endtask

    // hold off until every outstanding result has come back
    task automatic drain_results();
        start <= 1'b0;
        // pending count is registered in the checker, so it lags the transfer
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    // random requests; insert share wanders so the list both fills and empties
    task automatic run_random_phase(input int items, input int idle_pct);
        lrupl_req_t r;
        int         insert_pct;
        int         pick;
        insert_pct = 35;
        for (int n = 0; n < items; n++)
        begin
            if (n % 64 == 0)
                insert_pct = $urandom_range(60, 15);
            if ($urandom_range(99) < insert_pct)
                r.req_type = REQ_INSERT;
            else
            begin
                pick = $urandom_range(9);
                if (pick < 4)
                    r.req_type = REQ_ACCESS;
                else if (pick < 7)
                    r.req_type = REQ_EVICT;
                else
                    r.req_type = REQ_SETRES;
            end
            // mostly a small pool of pages so accesses hit and duplicates pile up
            if ($urandom_range(3) == 0)
                r.page_number = PAGE_W'($urandom_range(63));
            else
                r.page_number = PAGE_W'($urandom_range(11));
            r.resident = ($urandom_range(9) < 6);
            send_request(r, idle_pct);
            // now and then let the pipeline run dry
            if ($urandom_range(99) == 0)
                drain_results();
        end
    endtask

    initial
    begin
        int fill_pages [14] = '{1, 2, 3, 4, 5, 5, 6, 8, 10, 12, 20, 33, 40, 50};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // empty list: evict finds nothing, access misses
        send_request(page_req(REQ_EVICT, 0, 1'b0), 0);
        send_request(page_req(REQ_ACCESS, 7, 1'b0), 0);
        // pages 0 and 63 resident
        send_request(page_req(REQ_SETRES, 63, 1'b1), 0);
        send_request(page_req(REQ_SETRES, 0, 1'b1), 0);
        // fill to capacity with a duplicate page on the way
        send_request(page_req(REQ_INSERT, 0, 1'b0), 0);
        send_request(page_req(REQ_INSERT, 63, 1'b1), 0);
        foreach (fill_pages[k])
            send_request(page_req(REQ_INSERT, fill_pages[k], 1'b0), 0);
        // insert into a full list is rejected
        send_request(page_req(REQ_INSERT, 9, 1'b0), 0);
        // hit at front, hit at back, miss
        send_request(page_req(REQ_ACCESS, 50, 1'b0), 0);
        send_request(page_req(REQ_ACCESS, 0, 1'b0), 0);
        send_request(page_req(REQ_ACCESS, 42, 1'b0), 0);
        // evict from the back, then from the front, then nothing resident left
        send_request(page_req(REQ_EVICT, 0, 1'b0), 0);
        send_request(page_req(REQ_EVICT, 63, 1'b1), 0);
        send_request(page_req(REQ_EVICT, 0, 1'b0), 0);
        send_request(page_req(REQ_SETRES, 0, 1'b0), 0);
        drain_results();

        run_random_phase(PHASE_ITEMS, 33);
        drain_results();
        run_random_phase(PHASE_ITEMS, 55);
        drain_results();
        run_random_phase(PHASE_ITEMS, 0);

        drain_results();
        // catch any stray result after the last one
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d requests (insert %0d, access %0d, evict %0d, residency %0d)",
                 sent_by_type[REQ_INSERT] + sent_by_type[REQ_ACCESS]
                 + sent_by_type[REQ_EVICT] + sent_by_type[REQ_SETRES],
                 sent_by_type[REQ_INSERT], sent_by_type[REQ_ACCESS],
                 sent_by_type[REQ_EVICT], sent_by_type[REQ_SETRES]);
        $display("summary: %0d results checked, %0d full rejects, %0d misses or empty evicts, %0d errors",
                 checked_count, full_count, none_count, error_count);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
